// ----- hdl/sidac_pkg.sv -----
// sidac_pkg: shared types and constants for the signed integer to decimal
// ASCII unit. No dependencies.
package sidac_pkg;

  localparam logic [7:0] DIGIT_BASE = 8'd48;  // '0'
  localparam logic [7:0] MINUS_CODE = 8'd45;  // '-'

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_SIGN,
    ST_DIGITS
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;         // capture a new request, form magnitude
    logic shift;        // one double-dabble step
    logic digit_shift;  // drop the top BCD digit
    logic load_char;    // write output character register
    logic char_sign;    // character is '-' rather than the top digit
    logic char_last;    // tlast for the written character
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic conv_done;   // this shift is the final one
    logic neg;         // value was negative
    logic top_zero;    // top BCD digit is zero
    logic last_digit;  // only one digit remains
  } sts_t;

endpackage

// ----- hdl/signed_int_to_decimal_ascii_unit.sv -----
// signed_int_to_decimal_ascii_unit: top level, streams a signed integer in
// and its decimal ASCII text out. Depends on sidac_pkg, sidac_ctrl,
// sidac_datapath.
//
// Each request on the slave side carries one two's-complement value; the
// master side returns its decimal text one character per transfer, most
// significant digit first, with no leading zeros, a leading '-' for negative
// values, a single '0' for zero, and tlast on the final character. The most
// negative value prints correctly. A request is taken only while the unit is
// idle; a request then passes through an accept step, VALUE_BITS steps of
// shift-and-add-3 conversion in the datapath (one bit per cycle), a sign step
// if negative, and one step per BCD digit position (10 at the default width),
// leading zeros being dropped one per cycle. The output character sits in its
// own register, so the next request can be taken while the last character
// still waits.
module signed_int_to_decimal_ascii_unit #(
  parameter int VALUE_BITS = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // [VALUE_BITS-1:0] value, rest zero padding
  input  logic [((VALUE_BITS + 7) / 8) * 8 - 1:0] s_tdata,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // [7:0] char_code
  output logic [7:0]                            m_tdata,
  output logic                                  m_tlast
);

  sidac_pkg::cmd_t cmd;
  sidac_pkg::sts_t sts;

  sidac_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  sidac_datapath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk       (clk),
    .cmd       (cmd),
    .sts       (sts),
    .value     (s_tdata[VALUE_BITS-1:0]),
    .char_code (m_tdata),
    .is_last   (m_tlast)
  );

endmodule

// ----- hdl/sidac_datapath.sv -----
// sidac_datapath: magnitude register, double-dabble BCD converter and the
// output character register. Depends on sidac_pkg.
module sidac_datapath #(
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk,
  input  sidac_pkg::cmd_t       cmd,
  output sidac_pkg::sts_t       sts,
  input  logic [VALUE_BITS-1:0] value,
  output logic [7:0]            char_code,
  output logic                  is_last
);

  // digits of the largest VALUE_BITS-bit magnitude (1233/4096 ~ log10 2)
  localparam int NDIG   = (VALUE_BITS * 1233) / 4096 + 1;
  localparam int BCD_W  = NDIG * 4;
  localparam int CNT_W  = $clog2(VALUE_BITS);
  localparam int DCNT_W = $clog2(NDIG + 1);

  logic [VALUE_BITS-1:0] mag;
  logic [BCD_W-1:0]      bcd;
  logic [BCD_W-1:0]      bcd_adj;
  logic [CNT_W-1:0]      cnt;
  logic [DCNT_W-1:0]     dcnt;
  logic                  neg;
  logic [3:0]            top;

  assign top = bcd[BCD_W-1 -: 4];

  // add 3 to every digit at five or more before the shift
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      if (bcd[i*4 +: 4] >= 4'd5) begin
        bcd_adj[i*4 +: 4] = bcd[i*4 +: 4] + 4'd3;
      end else begin
        bcd_adj[i*4 +: 4] = bcd[i*4 +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      neg  <= value[VALUE_BITS-1];
      mag  <= value[VALUE_BITS-1] ? (~value + VALUE_BITS'(1)) : value;
      bcd  <= '0;
      cnt  <= CNT_W'(VALUE_BITS - 1);
      dcnt <= DCNT_W'(NDIG);
    end else if (cmd.shift) begin
      bcd <= {bcd_adj[BCD_W-2:0], mag[VALUE_BITS-1]};
      mag <= {mag[VALUE_BITS-2:0], 1'b0};
      cnt <= cnt - CNT_W'(1);
    end else if (cmd.digit_shift) begin
      bcd  <= {bcd[BCD_W-5:0], 4'd0};
      dcnt <= dcnt - DCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_char) begin
      char_code <= cmd.char_sign ? sidac_pkg::MINUS_CODE
                                 : sidac_pkg::DIGIT_BASE + {4'd0, top};
      is_last   <= cmd.char_last;
    end
  end

  always_comb begin
    sts.conv_done  = (cnt == '0);
    sts.neg        = neg;
    sts.top_zero   = (top == 4'd0);
    sts.last_digit = (dcnt == DCNT_W'(1));
  end

endmodule

// ----- hdl/sidac_ctrl.sv -----
// sidac_ctrl: sequencer for conversion and character emission, plus the
// output valid flag. Depends on sidac_pkg.
module sidac_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output sidac_pkg::cmd_t cmd,
  input  sidac_pkg::sts_t sts
);

  sidac_pkg::state_t state, state_next;
  logic started, started_next;
  logic out_valid_next;
  logic out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sidac_pkg::ST_IDLE;
      started   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      started   <= started_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next   = state;
    started_next = started;
    cmd          = '0;
    in_ready     = 1'b0;
    case (state)
      sidac_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load     = 1'b1;
          started_next = 1'b0;
          state_next   = sidac_pkg::ST_CONVERT;
        end
      end
      sidac_pkg::ST_CONVERT: begin
        cmd.shift = 1'b1;
        if (sts.conv_done) begin
          state_next = sts.neg ? sidac_pkg::ST_SIGN : sidac_pkg::ST_DIGITS;
        end
      end
      sidac_pkg::ST_SIGN: begin
        if (out_free) begin
          cmd.load_char = 1'b1;
          cmd.char_sign = 1'b1;
          state_next    = sidac_pkg::ST_DIGITS;
        end
      end
      sidac_pkg::ST_DIGITS: begin
        if (!started && sts.top_zero && !sts.last_digit) begin
          // leading zero: drop without emitting
          cmd.digit_shift = 1'b1;
        end else if (out_free) begin
          cmd.load_char   = 1'b1;
          cmd.char_last   = sts.last_digit;
          cmd.digit_shift = 1'b1;
          started_next    = 1'b1;
          if (sts.last_digit) begin
            state_next = sidac_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_next = sidac_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.load_char) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  // a held character is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_char |-> (!out_valid || out_ready))
    else $error("output character overwritten while stalled");

  // an accepted request starts conversion next cycle
  a_load_convert: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == sidac_pkg::ST_CONVERT))
    else $error("request accepted without conversion");

  // final character returns the sequencer to idle
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.load_char && cmd.char_last) |=> (state == sidac_pkg::ST_IDLE && out_valid))
    else $error("final character did not end the run");

  // the last remaining digit is always emitted, never skipped
  a_no_skip_last: assert property (@(posedge clk) disable iff (rst)
    (cmd.digit_shift && !cmd.load_char) |-> !sts.last_digit)
    else $error("final digit skipped");

endmodule

// ----- bench/decimal_text_checker.sv -----
// decimal_text_checker: watches both stream channels of the signed integer to
// decimal ASCII unit, predicts the text of each accepted value and compares.
// Depends on sidac_pkg for the character codes.
`timescale 1ns / 1ps

module decimal_text_checker #(
  parameter int VALUE_BITS = 32
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    s_tvalid,
  input  logic                                    s_tready,
  // [VALUE_BITS-1:0] value, rest zero padding
  input  logic [((VALUE_BITS + 7) / 8) * 8 - 1:0] s_tdata,
  input  logic                                    m_tvalid,
  input  logic                                    m_tready,
  // [7:0] char_code
  input  logic [7:0]                              m_tdata,
  input  logic                                    m_tlast,
  output int                                      failures,
  output int                                      outstanding,
  output int                                      chars_checked
);

  typedef struct packed {
    logic [7:0] char_code;
    logic       is_last;
  } text_char_t;

  text_char_t pending_text[$];

  // Appends the expected characters of one value, sign first.
  function automatic void render_decimal(input logic [VALUE_BITS-1:0] value);
    logic [VALUE_BITS:0] mag;
    logic [3:0]          digits[$];
    text_char_t          ch;
    if (value[VALUE_BITS-1]) begin
      mag = ~{1'b1, value} + 1'b1;
    end else begin
      mag = {1'b0, value};
    end
    // zero still yields one digit
    do begin
      digits.push_front(4'(mag % 10));
      mag = mag / 10;
    end while (mag != 0);
    if (value[VALUE_BITS-1]) begin
      ch.char_code = sidac_pkg::MINUS_CODE;
      ch.is_last   = 1'b0;
      pending_text.push_back(ch);
    end
    foreach (digits[i]) begin
      ch.char_code = sidac_pkg::DIGIT_BASE + 8'(digits[i]);
      ch.is_last   = (i == digits.size() - 1);
      pending_text.push_back(ch);
    end
  endfunction

  always @(posedge clk) begin
    text_char_t want;
    int         errs;
    errs = 0;
    if (rst) begin
      pending_text.delete();
      failures      <= 0;
      outstanding   <= 0;
      chars_checked <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        render_decimal(s_tdata[VALUE_BITS-1:0]);
      end
      if (m_tvalid && m_tready) begin
        if (pending_text.size() == 0) begin
          $error("unexpected character: char_code %0d is_last %0b", m_tdata, m_tlast);
          errs++;
        end else begin
          want = pending_text.pop_front();
          if (m_tdata !== want.char_code) begin
            $error("char_code mismatch: expected %0d, got %0d", want.char_code, m_tdata);
            errs++;
          end
          if (m_tlast !== want.is_last) begin
            $error("is_last mismatch: expected %0b, got %0b", want.is_last, m_tlast);
            errs++;
          end
        end
        chars_checked <= chars_checked + 1;
      end
      failures    <= failures + errs;
      outstanding <= pending_text.size();
    end
  end

endmodule

// ----- bench/tb_signed_int_to_decimal_ascii_unit.sv -----
// tb_signed_int_to_decimal_ascii_unit: drives values into the decimal ASCII
// unit under several idle/stall mixes and reports the verdict.
// Depends on signed_int_to_decimal_ascii_unit, decimal_text_checker, sidac_pkg.
`timescale 1ns / 1ps

module tb_signed_int_to_decimal_ascii_unit;

  localparam int VALUE_BITS  = 32;
  localparam int DATA_BITS   = ((VALUE_BITS + 7) / 8) * 8;
  localparam int CYCLE_LIMIT = 1_000_000;
  // idle tail after the final drain; leave generous room
  localparam int TAIL_CYCLES = 60;
  localparam int PHASE_ITEMS = 112;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  // [31:0] value
  logic [DATA_BITS-1:0] s_tdata = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  // [7:0] char_code
  logic [7:0]           m_tdata;
  logic                 m_tlast;

  int failures;
  int outstanding;
  int chars_checked;
  int cycle_count = 0;
  int values_sent = 0;
  int idle_pct = 0;   // chance per cycle that the sender holds back
  int stall_pct = 0;  // chance per cycle that the receiver stalls

  // Extremes, zero, the most negative value, digit-count boundaries and
  // alternating bit patterns.
  logic [31:0] directed_values [0:21] = '{
    32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
    -32'sd100, 32'd2147483647, 32'h80000000, -32'sd2147483647,
    32'd1000000000, 32'd999999999, -32'sd999999999, 32'd1234567890,
    -32'sd1234567890, 32'd5, -32'sd5, 32'h55555555, 32'hAAAAAAAA,
    -32'sd1000000000
  };

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  signed_int_to_decimal_ascii_unit #(
    .VALUE_BITS(VALUE_BITS)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
  );

  decimal_text_checker #(
    .VALUE_BITS(VALUE_BITS)
  ) text_check (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tlast      (m_tlast),
    .failures     (failures),
    .outstanding  (outstanding),
    .chars_checked(chars_checked)
  );

  // Receiver back-pressure, redrawn every cycle.
  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb_signed_int_to_decimal_ascii_unit NOT OK");
      $finish;
    end
  end

  // One request: optional idle cycles, then hold tvalid until accepted.
  // tvalid stays high on return so back-to-back requests need no gap.
  task automatic send_value(input logic [31:0] value);
    while ($urandom_range(0, 99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= value;
    do @(posedge clk); while (!s_tready);
    values_sent++;
  endtask

  // Sender holds off until every predicted character has been seen.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Random value: a third fully random bits, the rest spread evenly over
  // digit counts so short and long texts both show up often.
  function automatic logic [31:0] pick_value();
    int unsigned ndig;
    int unsigned lo;
    int unsigned hi;
    int unsigned mag;
    logic        neg;
    if ($urandom_range(0, 2) == 0) return $urandom();
    ndig = $urandom_range(1, 10);
    neg  = 1'($urandom_range(0, 1));
    lo   = 1;
    repeat (ndig - 1) lo = lo * 10;
    if (ndig == 10) begin
      hi = neg ? 32'd2147483648 : 32'd2147483647;
    end else begin
      hi = lo * 10 - 1;
    end
    if (ndig == 1) lo = 0;
    mag = $urandom_range(hi, lo);
    return neg ? 32'(0 - mag) : 32'(mag);
  endfunction

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part at full rate
    foreach (directed_values[i]) send_value(directed_values[i]);
    wait_drained();

    // random part: no idling, sender idle, receiver stalling, both
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 62;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 62;
        end
        default: begin
          idle_pct  = 32;
          stall_pct = 32;
        end
      endcase
      repeat (PHASE_ITEMS) send_value(pick_value());
      // drain fully between phases so the unit also restarts from quiet
      wait_drained();
    end

    idle_pct  = 0;
    stall_pct = 0;
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d values: zero, both extremes, every digit count, random bits",
             values_sent);
    $display("under four sender/receiver idle mixes; %0d characters compared",
             chars_checked);
    if (failures == 0 && outstanding == 0) begin
      $display("tb_signed_int_to_decimal_ascii_unit OK");
    end else begin
      $display("tb_signed_int_to_decimal_ascii_unit NOT OK");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/sidac_pkg.sv
hdl/sidac_datapath.sv
hdl/sidac_ctrl.sv
hdl/signed_int_to_decimal_ascii_unit.sv
bench/decimal_text_checker.sv
bench/tb_signed_int_to_decimal_ascii_unit.sv
